/* src/qmc_pkg.sv */
// shared types, widths and constants for the quadtree merge check core
`timescale 1ns / 1ps

package qmc_pkg;

    localparam int NUM_CELLS = 4;
    localparam int NUM_CHAN  = 3;
    localparam int NUM_PAIRS = 6;

    localparam int CHAN_W    = 8;
    localparam int PSUM_W    = CHAN_W + 1;
    localparam int SUM_W     = CHAN_W + 2;
    localparam int SQ_W      = 2 * CHAN_W;
    localparam int DIST_W    = SQ_W + 2;
    localparam int THR_W     = 9;
    localparam int THR_SQ_W  = 2 * THR_W;
    localparam int BOUND_W   = THR_SQ_W + 2;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // accept edge to the edge that takes the result
    localparam int PIPE_DEPTH = 5;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // cell pairs (0,1) (0,2) (0,3) (1,2) (1,3) (2,3), pair 0 at the right
    localparam logic [NUM_PAIRS-1:0][1:0] PAIR_A =
        {2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
    localparam logic [NUM_PAIRS-1:0][1:0] PAIR_B =
        {2'd3, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1};

    localparam logic              COLOR_MODE_RESET = 1'b1;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET  = 9'd16;

    typedef enum logic [0:0] {
        REG_COLOR_MODE = 1'b0,
        REG_THRESHOLD  = 1'b1
    } reg_idx_t;

    // channel 0 red, 1 green, 2 blue
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;
    typedef pixel_t [NUM_CELLS-1:0] quad_t;

    typedef struct packed {
        logic             color_mode;
        logic [THR_W-1:0] threshold;
    } cfg_t;

    typedef struct packed {
        logic [NUM_PAIRS-1:0][NUM_CHAN-1:0][SQ_W-1:0] sq;
        logic [CHAN_W-1:0]                            spread;
        pixel_t                                       mean;
        logic [BOUND_W-1:0]                           bound;
        logic                                         color_mode;
        logic [THR_W-1:0]                             threshold;
    } front_t;

    typedef struct packed {
        logic   may_merge;
        pixel_t mean;
    } result_t;

endpackage

/* src/qmc_cfg.sv */
// apb register file holding color mode and similarity threshold
`timescale 1ns / 1ps

module qmc_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qmc_pkg::APB_AW-1:0]  paddr,
    input  logic [qmc_pkg::APB_DW-1:0]  pwdata,
    output logic [qmc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output qmc_pkg::cfg_t               cfg
);

    logic                          color_mode_reg;
    logic                          color_mode_next;
    logic [qmc_pkg::THR_W-1:0]     threshold_reg;
    logic [qmc_pkg::THR_W-1:0]     threshold_next;
    logic                          wr_en;
    qmc_pkg::reg_idx_t             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = qmc_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        color_mode_next = color_mode_reg;
        threshold_next  = threshold_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                qmc_pkg::REG_COLOR_MODE: color_mode_next = pwdata[0];
                qmc_pkg::REG_THRESHOLD:  threshold_next  = pwdata[qmc_pkg::THR_W-1:0];
                default:                 color_mode_next = color_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= qmc_pkg::COLOR_MODE_RESET;
            threshold_reg  <= qmc_pkg::THRESHOLD_RESET;
        end
        else
        begin
            color_mode_reg <= color_mode_next;
            threshold_reg  <= threshold_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            qmc_pkg::REG_COLOR_MODE:
                prdata = {{(qmc_pkg::APB_DW-1){1'b0}}, color_mode_reg};
            qmc_pkg::REG_THRESHOLD:
                prdata = {{(qmc_pkg::APB_DW-qmc_pkg::THR_W){1'b0}}, threshold_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.color_mode = color_mode_reg;
    assign cfg.threshold  = threshold_reg;

endmodule

/* src/qmc_front.sv */
// stages one and two: channel differences, squares, red spread, means, bound
`timescale 1ns / 1ps

module qmc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  qmc_pkg::quad_t       quad,
    input  qmc_pkg::cfg_t        cfg,
    output logic                 out_valid,
    output qmc_pkg::front_t      out_data
);

    localparam int CW = qmc_pkg::CHAN_W;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // stage one
    logic                                                                s1_valid_reg;
    logic [qmc_pkg::NUM_PAIRS-1:0][qmc_pkg::NUM_CHAN-1:0][CW-1:0]        s1_diff_reg;
    logic [qmc_pkg::NUM_PAIRS-1:0][qmc_pkg::NUM_CHAN-1:0][CW-1:0]        s1_diff_next;
    logic [1:0][CW-1:0]                                                  s1_lo_reg;
    logic [1:0][CW-1:0]                                                  s1_lo_next;
    logic [1:0][CW-1:0]                                                  s1_hi_reg;
    logic [1:0][CW-1:0]                                                  s1_hi_next;
    logic [1:0][qmc_pkg::NUM_CHAN-1:0][qmc_pkg::PSUM_W-1:0]              s1_psum_reg;
    logic [1:0][qmc_pkg::NUM_CHAN-1:0][qmc_pkg::PSUM_W-1:0]              s1_psum_next;
    logic [qmc_pkg::THR_SQ_W-1:0]                                        s1_thr_sq_reg;
    logic [qmc_pkg::THR_SQ_W-1:0]                                        s1_thr_sq_next;
    qmc_pkg::cfg_t                                                       s1_cfg_reg;

    // stage two
    logic                 s2_valid_reg;
    qmc_pkg::front_t      s2_data_reg;
    qmc_pkg::front_t      s2_data_next;

    always_comb
    begin
        logic [CW-1:0] ra;
        logic [CW-1:0] rb;
        for (int p = 0; p < qmc_pkg::NUM_PAIRS; p++)
        begin
            for (int c = 0; c < qmc_pkg::NUM_CHAN; c++)
            begin
                s1_diff_next[p][c] = abs_diff(quad[qmc_pkg::PAIR_A[p]][c],
                                              quad[qmc_pkg::PAIR_B[p]][c]);
            end
        end
        for (int h = 0; h < 2; h++)
        begin
            ra = quad[2*h][qmc_pkg::CH_RED];
            rb = quad[2*h+1][qmc_pkg::CH_RED];
            s1_lo_next[h] = (ra < rb) ? ra : rb;
            s1_hi_next[h] = (ra > rb) ? ra : rb;
            for (int c = 0; c < qmc_pkg::NUM_CHAN; c++)
            begin
                s1_psum_next[h][c] = qmc_pkg::PSUM_W'(quad[2*h][c])
                                   + qmc_pkg::PSUM_W'(quad[2*h+1][c]);
            end
        end
        s1_thr_sq_next = qmc_pkg::THR_SQ_W'(cfg.threshold)
                       * qmc_pkg::THR_SQ_W'(cfg.threshold);
    end

    always_comb
    begin
        logic [CW-1:0]                lo;
        logic [CW-1:0]                hi;
        logic [qmc_pkg::SUM_W-1:0]    sum;
        for (int p = 0; p < qmc_pkg::NUM_PAIRS; p++)
        begin
            for (int c = 0; c < qmc_pkg::NUM_CHAN; c++)
            begin
                s2_data_next.sq[p][c] = qmc_pkg::SQ_W'(s1_diff_reg[p][c])
                                      * qmc_pkg::SQ_W'(s1_diff_reg[p][c]);
            end
        end
        lo = (s1_lo_reg[0] < s1_lo_reg[1]) ? s1_lo_reg[0] : s1_lo_reg[1];
        hi = (s1_hi_reg[0] > s1_hi_reg[1]) ? s1_hi_reg[0] : s1_hi_reg[1];
        s2_data_next.spread = hi - lo;
        for (int c = 0; c < qmc_pkg::NUM_CHAN; c++)
        begin
            sum = qmc_pkg::SUM_W'(s1_psum_reg[0][c]) + qmc_pkg::SUM_W'(s1_psum_reg[1][c]);
            s2_data_next.mean[c] = sum[qmc_pkg::SUM_W-1:2];
        end
        // three times the square as shift and add
        s2_data_next.bound = (qmc_pkg::BOUND_W'(s1_thr_sq_reg) << 1)
                           + qmc_pkg::BOUND_W'(s1_thr_sq_reg);
        s2_data_next.color_mode = s1_cfg_reg.color_mode;
        s2_data_next.threshold  = s1_cfg_reg.threshold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_diff_reg   <= s1_diff_next;
        s1_lo_reg     <= s1_lo_next;
        s1_hi_reg     <= s1_hi_next;
        s1_psum_reg   <= s1_psum_next;
        s1_thr_sq_reg <= s1_thr_sq_next;
        s1_cfg_reg    <= cfg;
        s2_data_reg   <= s2_data_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

/* src/qmc_back.sv */
// stages three to five: pair distances, worst distance, merge decision
`timescale 1ns / 1ps

module qmc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  qmc_pkg::front_t      in_data,
    output logic                 out_valid,
    output qmc_pkg::result_t     out_data
);

    localparam int DW = qmc_pkg::DIST_W;

    // stage three
    logic                                      s3_valid_reg;
    logic [qmc_pkg::NUM_PAIRS-1:0][DW-1:0]     s3_dist_reg;
    logic [qmc_pkg::NUM_PAIRS-1:0][DW-1:0]     s3_dist_next;
    logic                                      s3_gray_ok_reg;
    logic                                      s3_gray_ok_next;
    logic [qmc_pkg::BOUND_W-1:0]               s3_bound_reg;
    logic                                      s3_mode_reg;
    qmc_pkg::pixel_t                           s3_mean_reg;

    // stage four
    logic                                      s4_valid_reg;
    logic [1:0][DW-1:0]                        s4_max_reg;
    logic [1:0][DW-1:0]                        s4_max_next;
    logic                                      s4_gray_ok_reg;
    logic [qmc_pkg::BOUND_W-1:0]               s4_bound_reg;
    logic                                      s4_mode_reg;
    qmc_pkg::pixel_t                           s4_mean_reg;

    // stage five
    logic                                      s5_valid_reg;
    qmc_pkg::result_t                          s5_data_reg;
    qmc_pkg::result_t                          s5_data_next;

    always_comb
    begin
        for (int p = 0; p < qmc_pkg::NUM_PAIRS; p++)
        begin
            s3_dist_next[p] = DW'(in_data.sq[p][qmc_pkg::CH_RED])
                            + DW'(in_data.sq[p][qmc_pkg::CH_GREEN])
                            + DW'(in_data.sq[p][qmc_pkg::CH_BLUE]);
        end
        s3_gray_ok_next = qmc_pkg::THR_W'(in_data.spread) < in_data.threshold;
    end

    // two groups of three pairs
    always_comb
    begin
        logic [DW-1:0] m;
        for (int g = 0; g < 2; g++)
        begin
            m = (s3_dist_reg[3*g] > s3_dist_reg[3*g+1]) ? s3_dist_reg[3*g]
                                                        : s3_dist_reg[3*g+1];
            s4_max_next[g] = (s3_dist_reg[3*g+2] > m) ? s3_dist_reg[3*g+2] : m;
        end
    end

    always_comb
    begin
        logic [DW-1:0] worst;
        worst = (s4_max_reg[0] > s4_max_reg[1]) ? s4_max_reg[0] : s4_max_reg[1];
        s5_data_next.may_merge = s4_mode_reg ? (qmc_pkg::BOUND_W'(worst) < s4_bound_reg)
                                             : s4_gray_ok_reg;
        s5_data_next.mean      = s4_mean_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= in_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_dist_reg    <= s3_dist_next;
        s3_gray_ok_reg <= s3_gray_ok_next;
        s3_bound_reg   <= in_data.bound;
        s3_mode_reg    <= in_data.color_mode;
        s3_mean_reg    <= in_data.mean;
        s4_max_reg     <= s4_max_next;
        s4_gray_ok_reg <= s3_gray_ok_reg;
        s4_bound_reg   <= s3_bound_reg;
        s4_mode_reg    <= s3_mode_reg;
        s4_mean_reg    <= s3_mean_reg;
        s5_data_reg    <= s5_data_next;
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = s5_data_reg;

endmodule

/* src/quadtree_merge_check_core.sv */
// top level of the quadtree merge check core: ports, config and pipeline
`timescale 1ns / 1ps
// path: a taken request passes the stage one to stage five valid registers in order,
//   and done is driven by the stage five valid register
// throughput: one request every cycle; busy stays low since the five-stage
//   pipeline never holds and the receiver cannot stall the strobe
// reset: rst_n async low clears the stage valid bits and loads color_mode 1,
//   similarity_threshold 16; no memory, no clearing pass

module quadtree_merge_check_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        start,
    output logic                        busy,
    input  logic [7:0]                  tl_red,
    input  logic [7:0]                  tl_green,
    input  logic [7:0]                  tl_blue,
    input  logic [7:0]                  tr_red,
    input  logic [7:0]                  tr_green,
    input  logic [7:0]                  tr_blue,
    input  logic [7:0]                  bl_red,
    input  logic [7:0]                  bl_green,
    input  logic [7:0]                  bl_blue,
    input  logic [7:0]                  br_red,
    input  logic [7:0]                  br_green,
    input  logic [7:0]                  br_blue,
    // result strobe
    output logic                        done,
    output logic                        may_merge,
    output logic [7:0]                  mean_red,
    output logic [7:0]                  mean_green,
    output logic [7:0]                  mean_blue,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qmc_pkg::APB_AW-1:0]  paddr,
    input  logic [qmc_pkg::APB_DW-1:0]  pwdata,
    output logic [qmc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    qmc_pkg::cfg_t       cfg;
    qmc_pkg::quad_t      quad;
    qmc_pkg::front_t     front_data;
    qmc_pkg::result_t    result;
    logic                req_take;
    logic                front_valid;

    // every stage advances each cycle, so a request is always taken
    assign busy     = 1'b0;
    assign req_take = start && !busy;

    // cell order tl, tr, bl, br; channel order red, green, blue
    assign quad[0] = {tl_blue, tl_green, tl_red};
    assign quad[1] = {tr_blue, tr_green, tr_red};
    assign quad[2] = {bl_blue, bl_green, bl_red};
    assign quad[3] = {br_blue, br_green, br_red};

    qmc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // abs differences and squares, red spread, channel means, 3*t*t
    qmc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_take),
        .quad      (quad),
        .cfg       (cfg),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    // pair distances, max over six pairs, final strict compares
    qmc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (done),
        .out_data  (result)
    );

    assign may_merge  = result.may_merge;
    assign mean_red   = result.mean[qmc_pkg::CH_RED];
    assign mean_green = result.mean[qmc_pkg::CH_GREEN];
    assign mean_blue  = result.mean[qmc_pkg::CH_BLUE];

    // every request gives exactly one strobe after the pipeline depth
    assert property (@(posedge clk) disable iff (!rst_n)
        req_take |-> ##(qmc_pkg::PIPE_DEPTH) done)
        else $error("request did not produce a result strobe");

    // no strobe without a request the pipeline depth earlier
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req_take, qmc_pkg::PIPE_DEPTH))
        else $error("result strobe without a matching request");

    // front stage valid follows a request through the stage one and stage two valid registers
    assert property (@(posedge clk) disable iff (!rst_n)
        front_valid |-> $past(req_take, 2))
        else $error("front stage valid without a request");

endmodule
